@@ sv/hpgd_pkg.sv @@
// Package: shared types and constants for the hand press gesture detector.
package hpgd_pkg;

	localparam int TimeW   = 32;
	localparam int CoordW  = 14;
	localparam int DiffW   = CoordW + 1;
	localparam int SqW     = 2 * CoordW;
	localparam int SumW    = SqW + 2;
	localparam int MsW     = 16;
	localparam int MmW     = 10;
	localparam int MmSqW   = 2 * MmW;
	localparam int ApbAddrW = 5;
	localparam int ApbDataW = 32;

	localparam logic [MsW-1:0] HistoryMsRst       = 16'd2000;
	localparam logic [MsW-1:0] StartEarliestMsRst = 16'd500;
	localparam logic [MsW-1:0] StartLatestMsRst   = 16'd100;
	localparam logic [MmW-1:0] StillLimitMmRst    = 10'd20;
	localparam logic [MmW-1:0] TravelLimitMmRst   = 10'd20;

	typedef logic signed [CoordW-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} pos_t;

	typedef struct packed {
		logic [TimeW-1:0] time_ms;
		pos_t             pos;
	} entry_t;

	typedef struct packed {
		logic [MsW-1:0] history_ms;
		logic [MsW-1:0] start_earliest_ms;
		logic [MsW-1:0] start_latest_ms;
		logic [MmW-1:0] still_limit_mm;
		logic [MmW-1:0] travel_limit_mm;
	} cfg_t;

	typedef struct packed {
		logic           valid;
		logic           over_hist;
		logic           in_window;
		logic           y_below;
		logic [SqW-1:0] sq_x;
		logic [SqW-1:0] sq_y;
		logic [SqW-1:0] sq_z;
	} dist_t;

	typedef enum logic [2:0] {
		REG_HISTORY_MS        = 3'd0,
		REG_START_EARLIEST_MS = 3'd1,
		REG_START_LATEST_MS   = 3'd2,
		REG_STILL_LIMIT_MM    = 3'd3,
		REG_TRAVEL_LIMIT_MM   = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN_START,
		ST_SCAN_TRAVEL,
		ST_FINISH
	} state_t;

endpackage

@@ sv/hpgd_sample_if.sv @@
// Interface: input sample channel (valid/ready with timestamp and position).
interface hpgd_sample_if;
	logic                              valid;
	logic                              ready;
	logic [hpgd_pkg::TimeW-1:0]        time_ms;
	logic signed [hpgd_pkg::CoordW-1:0] pos_x_mm;
	logic signed [hpgd_pkg::CoordW-1:0] pos_y_mm;
	logic signed [hpgd_pkg::CoordW-1:0] pos_z_mm;

	modport source (output valid, output time_ms, output pos_x_mm, output pos_y_mm,
		output pos_z_mm, input ready);
	modport sink (input valid, input time_ms, input pos_x_mm, input pos_y_mm,
		input pos_z_mm, output ready);
endinterface

@@ sv/hpgd_result_if.sv @@
// Interface: result channel (valid/ready with press flag).
interface hpgd_result_if;
	logic valid;
	logic ready;
	logic press_detected;

	modport source (output valid, output press_detected, input ready);
	modport sink (input valid, input press_detected, output ready);
endinterface

@@ sv/hpgd_cfg.sv @@
// Configuration register file behind an APB-style port.
module hpgd_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [hpgd_pkg::ApbAddrW-1:0]  paddr,
	input  logic [hpgd_pkg::ApbDataW-1:0]  pwdata,
	output logic [hpgd_pkg::ApbDataW-1:0]  prdata,
	output logic                           pready,
	output hpgd_pkg::cfg_t                 cfg
);

	hpgd_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [2:0]     reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_sel = paddr[4:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.history_ms        <= hpgd_pkg::HistoryMsRst;
			cfg_q.start_earliest_ms <= hpgd_pkg::StartEarliestMsRst;
			cfg_q.start_latest_ms   <= hpgd_pkg::StartLatestMsRst;
			cfg_q.still_limit_mm    <= hpgd_pkg::StillLimitMmRst;
			cfg_q.travel_limit_mm   <= hpgd_pkg::TravelLimitMmRst;
		end else if (wr_en) begin
			case (reg_sel)
				hpgd_pkg::REG_HISTORY_MS: begin
					cfg_q.history_ms <= pwdata[hpgd_pkg::MsW-1:0];
				end
				hpgd_pkg::REG_START_EARLIEST_MS: begin
					cfg_q.start_earliest_ms <= pwdata[hpgd_pkg::MsW-1:0];
				end
				hpgd_pkg::REG_START_LATEST_MS: begin
					cfg_q.start_latest_ms <= pwdata[hpgd_pkg::MsW-1:0];
				end
				hpgd_pkg::REG_STILL_LIMIT_MM: begin
					cfg_q.still_limit_mm <= pwdata[hpgd_pkg::MmW-1:0];
				end
				hpgd_pkg::REG_TRAVEL_LIMIT_MM: begin
					cfg_q.travel_limit_mm <= pwdata[hpgd_pkg::MmW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			hpgd_pkg::REG_HISTORY_MS:        prdata = 32'(cfg_q.history_ms);
			hpgd_pkg::REG_START_EARLIEST_MS: prdata = 32'(cfg_q.start_earliest_ms);
			hpgd_pkg::REG_START_LATEST_MS:   prdata = 32'(cfg_q.start_latest_ms);
			hpgd_pkg::REG_STILL_LIMIT_MM:    prdata = 32'(cfg_q.still_limit_mm);
			hpgd_pkg::REG_TRAVEL_LIMIT_MM:   prdata = 32'(cfg_q.travel_limit_mm);
			default:                         prdata = '0;
		endcase
	end

endmodule

@@ sv/hpgd_dist.sv @@
// Shared distance unit: per-axis squares, age window flags and y test, registered.
module hpgd_dist (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  hpgd_pkg::entry_t  entry_s1,
	input  hpgd_pkg::entry_t  cur,
	input  hpgd_pkg::cfg_t    cfg,
	output hpgd_pkg::dist_t   res_s2
);

	logic signed [hpgd_pkg::DiffW-1:0]  dx, dy, dz;
	logic signed [2*hpgd_pkg::DiffW-1:0] px, py, pz;
	logic [hpgd_pkg::TimeW-1:0]          age;
	logic                                over_hist, in_window, y_below;

	logic                       valid_s2;
	logic                       over_hist_s2, in_window_s2, y_below_s2;
	logic [hpgd_pkg::SqW-1:0]   sq_x_s2, sq_y_s2, sq_z_s2;

	always_comb begin
		dx = $signed({entry_s1.pos.x[hpgd_pkg::CoordW-1], entry_s1.pos.x})
			- $signed({cur.pos.x[hpgd_pkg::CoordW-1], cur.pos.x});
		dy = $signed({entry_s1.pos.y[hpgd_pkg::CoordW-1], entry_s1.pos.y})
			- $signed({cur.pos.y[hpgd_pkg::CoordW-1], cur.pos.y});
		dz = $signed({entry_s1.pos.z[hpgd_pkg::CoordW-1], entry_s1.pos.z})
			- $signed({cur.pos.z[hpgd_pkg::CoordW-1], cur.pos.z});
		px = dx * dx;
		py = dy * dy;
		pz = dz * dz;
		// age wraps modulo 2^32, same as the timestamp
		age       = cur.time_ms - entry_s1.time_ms;
		over_hist = age > hpgd_pkg::TimeW'(cfg.history_ms);
		in_window = (age > hpgd_pkg::TimeW'(cfg.start_latest_ms))
			&& (age <= hpgd_pkg::TimeW'(cfg.start_earliest_ms));
		y_below   = $signed(entry_s1.pos.y) < $signed(cur.pos.y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			over_hist_s2 <= over_hist;
			in_window_s2 <= in_window;
			y_below_s2   <= y_below;
			sq_x_s2      <= px[hpgd_pkg::SqW-1:0];
			sq_y_s2      <= py[hpgd_pkg::SqW-1:0];
			sq_z_s2      <= pz[hpgd_pkg::SqW-1:0];
		end
	end

	assign res_s2 = '{valid: valid_s2, over_hist: over_hist_s2, in_window: in_window_s2,
		y_below: y_below_s2, sq_x: sq_x_s2, sq_y: sq_y_s2, sq_z: sq_z_s2};

endmodule

@@ sv/hand_press_gesture_detector.sv @@
// Hand press gesture detector, top level.
// Takes one timestamped hand-tip sample per transfer, stores it in a circular history of
// HISTORY_DEPTH entries and returns one press_detected result per sample. Work per sample:
// the sample is accepted and written, then a first pass over all n stored samples drops
// entries older than history_ms and finds the nearest start sample, then, only when that
// start is close enough, a second pass from the start sample to the newest entry finds
// the largest travel among samples below the current y; finally the result register is
// loaded. The time per sample is set by the single read port of the history memory, which
// feeds one entry per cycle into the shared distance unit. sample_ch.ready is low from
// acceptance until the result is loaded; a loaded result waits in its output register
// until taken. The history memory needs no clearing after reset: only entries that were
// written are ever read. Configuration is written through the APB port at byte address
// 4*i and should only change while no sample is in flight.
module hand_press_gesture_detector #(
	parameter int HISTORY_DEPTH = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	hpgd_sample_if.sink                    sample_ch,
	hpgd_result_if.source                  result_ch,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [hpgd_pkg::ApbAddrW-1:0]  paddr,
	input  logic [hpgd_pkg::ApbDataW-1:0]  pwdata,
	output logic [hpgd_pkg::ApbDataW-1:0]  prdata,
	output logic                           pready
);

	localparam int IdxW  = $clog2(HISTORY_DEPTH);
	localparam int CntW  = $clog2(HISTORY_DEPTH + 1);
	localparam int SlotW = IdxW + 1;
	localparam logic [CntW-1:0]  DepthCnt  = CntW'(HISTORY_DEPTH);
	localparam logic [SlotW-1:0] DepthSlot = SlotW'(HISTORY_DEPTH);
	localparam logic [IdxW-1:0]  LastIdx   = IdxW'(HISTORY_DEPTH - 1);

	hpgd_pkg::cfg_t   cfg;
	hpgd_pkg::dist_t  dres_s2;
	hpgd_pkg::state_t state_q, state_d;

	// history memory: time and position per entry
	hpgd_pkg::entry_t mem [HISTORY_DEPTH];
	hpgd_pkg::entry_t rd_s1;
	hpgd_pkg::entry_t cur_q;
	hpgd_pkg::entry_t new_entry;

	logic [IdxW-1:0]  wp_q;         // next write slot
	logic [IdxW-1:0]  base_q;       // slot of the oldest stored entry
	logic [CntW-1:0]  cnt_q;        // stored entries
	logic [CntW-1:0]  k_q;          // scan offset from the oldest entry
	logic [CntW-1:0]  k_s1, k_s2;
	logic             rd_valid_s1;

	logic             kept_q;       // first entry young enough has been seen
	logic [CntW-1:0]  keep_k_q;     // entries dropped from the old end
	logic             found_q;
	logic [CntW-1:0]  start_k_q;
	logic [hpgd_pkg::SumW-1:0] best_q, maxd_q, dsum;
	logic             press_q;

	logic             res_valid_q, res_press_q;

	logic             accept, scanning, issue_on, pipe_busy, scan_done;
	logic             travel_go, result_load;
	logic [SlotW-1:0] slot_wide, base_wide;
	logic [IdxW-1:0]  rd_slot, base_next;
	logic [hpgd_pkg::MmSqW-1:0] still_sq, travel_sq;

	hpgd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	hpgd_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (rd_valid_s1),
		.entry_s1 (rd_s1),
		.cur      (cur_q),
		.cfg      (cfg),
		.res_s2   (dres_s2)
	);

	assign new_entry = '{time_ms: sample_ch.time_ms,
		pos: '{x: sample_ch.pos_x_mm, y: sample_ch.pos_y_mm, z: sample_ch.pos_z_mm}};

	assign accept = sample_ch.valid & sample_ch.ready;

	// read slot: oldest plus scan offset, wrapped once
	assign slot_wide = SlotW'(base_q) + SlotW'(k_q);
	assign rd_slot   = (slot_wide >= DepthSlot) ? IdxW'(slot_wide - DepthSlot)
		: slot_wide[IdxW-1:0];

	// oldest slot after dropping keep_k_q entries
	assign base_wide = SlotW'(base_q) + SlotW'(keep_k_q);
	assign base_next = (base_wide >= DepthSlot) ? IdxW'(base_wide - DepthSlot)
		: base_wide[IdxW-1:0];

	assign still_sq  = hpgd_pkg::MmSqW'(cfg.still_limit_mm)
		* hpgd_pkg::MmSqW'(cfg.still_limit_mm);
	assign travel_sq = hpgd_pkg::MmSqW'(cfg.travel_limit_mm)
		* hpgd_pkg::MmSqW'(cfg.travel_limit_mm);

	assign dsum = hpgd_pkg::SumW'(dres_s2.sq_x) + hpgd_pkg::SumW'(dres_s2.sq_y)
		+ hpgd_pkg::SumW'(dres_s2.sq_z);

	assign pipe_busy = rd_valid_s1 | dres_s2.valid;
	assign travel_go = found_q && (best_q <= hpgd_pkg::SumW'(still_sq));

	// sequencer outputs
	always_comb begin
		sample_ch.ready = 1'b0;
		scanning        = 1'b0;
		result_load     = 1'b0;
		case (state_q)
			hpgd_pkg::ST_IDLE: begin
				sample_ch.ready = 1'b1;
			end
			hpgd_pkg::ST_SCAN_START, hpgd_pkg::ST_SCAN_TRAVEL: begin
				scanning = 1'b1;
			end
			hpgd_pkg::ST_FINISH: begin
				result_load = !res_valid_q || result_ch.ready;
			end
			default: begin
			end
		endcase
		issue_on  = scanning && (k_q < cnt_q);
		scan_done = scanning && !issue_on && !pipe_busy;
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			hpgd_pkg::ST_IDLE: begin
				if (accept) state_d = hpgd_pkg::ST_SCAN_START;
			end
			hpgd_pkg::ST_SCAN_START: begin
				if (scan_done) begin
					state_d = travel_go ? hpgd_pkg::ST_SCAN_TRAVEL : hpgd_pkg::ST_FINISH;
				end
			end
			hpgd_pkg::ST_SCAN_TRAVEL: begin
				if (scan_done) state_d = hpgd_pkg::ST_FINISH;
			end
			hpgd_pkg::ST_FINISH: begin
				if (result_load) state_d = hpgd_pkg::ST_IDLE;
			end
			default: begin
				state_d = hpgd_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hpgd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// memory: write on sample transfer, registered read during scans
	always_ff @(posedge clk) begin
		if (accept) mem[wp_q] <= new_entry;
		if (issue_on) rd_s1 <= mem[rd_slot];
	end

	// history pointers and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			base_q      <= '0;
			cnt_q       <= '0;
			k_q         <= '0;
			k_s1        <= '0;
			k_s2        <= '0;
			rd_valid_s1 <= 1'b0;
			kept_q      <= 1'b0;
			keep_k_q    <= '0;
			found_q     <= 1'b0;
			start_k_q   <= '0;
			press_q     <= 1'b0;
		end else begin
			rd_valid_s1 <= issue_on;
			k_s1        <= k_q;
			k_s2        <= k_s1;

			if (accept) begin
				wp_q     <= (wp_q == LastIdx) ? '0 : wp_q + IdxW'(1);
				// full history: the new entry overwrites the oldest
				if (cnt_q == DepthCnt) begin
					base_q <= (base_q == LastIdx) ? '0 : base_q + IdxW'(1);
				end else begin
					cnt_q <= cnt_q + CntW'(1);
				end
				k_q      <= '0;
				kept_q   <= 1'b0;
				keep_k_q <= '0;
				found_q  <= 1'b0;
			end else if (state_q == hpgd_pkg::ST_SCAN_START && scan_done && travel_go) begin
				k_q <= start_k_q;
			end else if (issue_on) begin
				k_q <= k_q + CntW'(1);
			end

			// first pass: stale entries at the old end are dropped until one is kept
			if (state_q == hpgd_pkg::ST_SCAN_START && dres_s2.valid) begin
				if (kept_q || !dres_s2.over_hist) begin
					if (!kept_q) begin
						kept_q   <= 1'b1;
						keep_k_q <= k_s2;
					end
					// strict compare keeps the oldest on ties
					if (dres_s2.in_window && (!found_q || dsum < best_q)) begin
						found_q   <= 1'b1;
						start_k_q <= k_s2;
					end
				end
			end

			if (state_q == hpgd_pkg::ST_SCAN_START && scan_done && !travel_go) begin
				press_q <= 1'b0;
			end else if (state_q == hpgd_pkg::ST_SCAN_TRAVEL && scan_done) begin
				press_q <= maxd_q > hpgd_pkg::SumW'(travel_sq);
			end

			// retire dropped entries once the sample is done
			if (result_load) begin
				cnt_q  <= cnt_q - keep_k_q;
				base_q <= base_next;
			end
		end
	end

	// distance trackers
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q  <= new_entry;
			best_q <= '0;
			maxd_q <= '0;
		end else if (dres_s2.valid) begin
			if (state_q == hpgd_pkg::ST_SCAN_START) begin
				if ((kept_q || !dres_s2.over_hist) && dres_s2.in_window
					&& (!found_q || dsum < best_q)) begin
					best_q <= dsum;
				end
			end else if (state_q == hpgd_pkg::ST_SCAN_TRAVEL) begin
				if (dres_s2.y_below && dsum > maxd_q) maxd_q <= dsum;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			res_press_q <= 1'b0;
		end else if (result_load) begin
			res_valid_q <= 1'b1;
			res_press_q <= press_q;
		end else if (result_ch.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign result_ch.valid          = res_valid_q;
	assign result_ch.press_detected = res_press_q;

endmodule
